FILE: rtl/awns_pkg.sv
// Shared types, constants and register codes of the affine warp sampler.
`default_nettype none
package awns_pkg;

  // Field widths
  localparam int PIXEL_W = 16;
  localparam int COORD_W = 12;
  localparam int COEF_W  = 32;
  localparam int IDX_W   = 3;

  // Default source size
  localparam int SRC_WIDTH_DEF  = 256;
  localparam int SRC_HEIGHT_DEF = 256;

  // Divider step count: 128-bit dividend, one bit a step
  localparam int DIV_STEPS = 128;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COEF_A     = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_B     = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_C     = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_D     = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_E     = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_F     = 3'd5;
  localparam logic [IDX_W-1:0] REG_FILL_LEVEL = 3'd6;

  // Function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Q16.16 one
  localparam logic [COEF_W-1:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               inside_res;
  } out_item_t;

  // Inverse matrix as seen by the query path
  typedef struct packed {
    logic [5:0][COEF_W-1:0] m;
    logic                   singular;
  } inv_t;

  typedef struct packed {
    logic        start;
    logic        sh32;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [COEF_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_ROUND
  } div_state_t;

  typedef enum logic [2:0] {
    INV_IDLE,
    INV_MUL,
    INV_SUB,
    INV_CHK,
    INV_DIVGO,
    INV_DIVWAIT
  } inv_state_t;

  typedef enum logic [2:0] {
    Q_IDLE,
    Q_MUL,
    Q_SUM,
    Q_CHK,
    Q_RD
  } qry_state_t;

endpackage
`default_nettype wire

FILE: rtl/awns_frame_ram.sv
// Source frame store: one write port, one registered read port.
`default_nettype none
module awns_frame_ram #(
  parameter int  DEPTH = awns_pkg::SRC_WIDTH_DEF * awns_pkg::SRC_HEIGHT_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [awns_pkg::PIXEL_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output logic [awns_pkg::PIXEL_W-1:0]    rdata
);

  logic [awns_pkg::PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/awns_divider.sv
// Restoring divider: round(num * 2^sh / den), ties away from zero, saturated to 32 bits.
`default_nettype none
module awns_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire awns_pkg::div_req_t req,
  output awns_pkg::div_rsp_t      rsp
);

  awns_pkg::div_state_t state, state_next;

  logic [2*64-1:0]                 dvd;
  logic [63:0]                     dmag;
  logic [63:0]                     rem;
  logic [32:0]                     q;
  logic                            ovf;
  logic                            neg;
  logic [awns_pkg::DIV_CNT_W-1:0]  count;

  logic [63:0] num_mag;
  logic [63:0] den_mag;
  logic [64:0] rs;
  logic        ge;
  logic [64:0] rdiff;
  logic [63:0] half;
  logic        inc;
  logic [33:0] qs;
  logic [32:0] lim;
  logic        sat;
  logic [32:0] qmag;

  // Magnitudes of the operands
  assign num_mag = req.num[63] ? (64'd0 - req.num) : req.num;
  assign den_mag = req.den[63] ? (64'd0 - req.den) : req.den;

  // One quotient bit a step
  assign rs    = {rem, dvd[2*64-1]};
  assign ge    = rs >= {1'b0, dmag};
  assign rdiff = rs - {1'b0, dmag};

  // Rounding and saturation on the final remainder
  assign half = dmag - rem;
  assign inc  = rem >= half;
  assign qs   = {1'b0, q} + {33'd0, inc};
  assign lim  = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign sat  = ovf || qs[33] || (qs[32:0] > lim);
  assign qmag = sat ? lim : qs[32:0];

  assign rsp.done = (state == awns_pkg::DIV_ROUND);
  assign rsp.quot = neg ? (32'd0 - qmag[31:0]) : qmag[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= awns_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      awns_pkg::DIV_IDLE:  state_next = awns_pkg::DIV_IDLE;
      awns_pkg::DIV_RUN:   if (count == '0) state_next = awns_pkg::DIV_ROUND;
      awns_pkg::DIV_ROUND: state_next = awns_pkg::DIV_IDLE;
      default:             state_next = awns_pkg::DIV_IDLE;
    endcase
    // a start restarts the unit from any state
    if (req.start) begin
      state_next = awns_pkg::DIV_RUN;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd   <= req.sh32 ? {32'd0, num_mag, 32'd0} : {48'd0, num_mag, 16'd0};
      dmag  <= den_mag;
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
      neg   <= req.num[63] ^ req.den[63];
      count <= awns_pkg::DIV_CNT_W'(awns_pkg::DIV_STEPS - 1);
    end else if (state == awns_pkg::DIV_RUN) begin
      dvd   <= {dvd[2*64-2:0], 1'b0};
      rem   <= ge ? rdiff[63:0] : rs[63:0];
      ovf   <= ovf | q[32];
      q     <= {q[31:0], ge};
      count <= count - awns_pkg::DIV_CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/awns_inverse.sv
// Coefficient registers and the sequencer that derives the inverse matrix.
`default_nettype none
module awns_inverse (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [awns_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [awns_pkg::COEF_W-1:0]  cfg_data,
  output awns_pkg::inv_t                    inv,
  output logic                              busy
);

  awns_pkg::inv_state_t state, state_next;

  logic [5:0][awns_pkg::COEF_W-1:0] coef;
  logic [5:0][63:0]                 prod;
  logic [63:0]                      det;
  logic [63:0]                      num_x;
  logic [63:0]                      num_y;
  logic [2:0]                       k;

  logic                             coef_wr;
  logic [awns_pkg::COEF_W-1:0]      op_l;
  logic [awns_pkg::COEF_W-1:0]      op_r;
  logic signed [63:0]               mul;
  awns_pkg::div_req_t               div_req;
  awns_pkg::div_rsp_t               div_rsp;

  assign coef_wr = cfg_wr_en && (cfg_index <= awns_pkg::REG_COEF_F);
  assign busy    = (state != awns_pkg::INV_IDLE);

  // Product order: a*e, b*d, b*f, c*e, c*d, a*f
  always_comb begin
    case (k)
      3'd0:    begin op_l = coef[0]; op_r = coef[4]; end
      3'd1:    begin op_l = coef[1]; op_r = coef[3]; end
      3'd2:    begin op_l = coef[1]; op_r = coef[5]; end
      3'd3:    begin op_l = coef[2]; op_r = coef[4]; end
      3'd4:    begin op_l = coef[2]; op_r = coef[3]; end
      3'd5:    begin op_l = coef[0]; op_r = coef[5]; end
      default: begin op_l = '0;      op_r = '0;      end
    endcase
  end

  assign mul = 64'($signed(op_l)) * 64'($signed(op_r));

  // Divider request: entries e, -b, x shift, -d, a, y shift over det
  always_comb begin
    div_req.start = (state == awns_pkg::INV_DIVGO);
    div_req.den   = det;
    case (k)
      3'd0:    begin div_req.num = 64'($signed(coef[4]));         div_req.sh32 = 1'b1; end
      3'd1:    begin div_req.num = 64'd0 - 64'($signed(coef[1])); div_req.sh32 = 1'b1; end
      3'd2:    begin div_req.num = num_x;                         div_req.sh32 = 1'b0; end
      3'd3:    begin div_req.num = 64'd0 - 64'($signed(coef[3])); div_req.sh32 = 1'b1; end
      3'd4:    begin div_req.num = 64'($signed(coef[0]));         div_req.sh32 = 1'b1; end
      3'd5:    begin div_req.num = num_y;                         div_req.sh32 = 1'b0; end
      default: begin div_req.num = '0;                            div_req.sh32 = 1'b1; end
    endcase
  end

  awns_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= awns_pkg::INV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      awns_pkg::INV_IDLE:    state_next = awns_pkg::INV_IDLE;
      awns_pkg::INV_MUL:     if (k == 3'd5) state_next = awns_pkg::INV_SUB;
      awns_pkg::INV_SUB:     state_next = awns_pkg::INV_CHK;
      awns_pkg::INV_CHK:     state_next = (det == '0) ? awns_pkg::INV_IDLE
                                                      : awns_pkg::INV_DIVGO;
      awns_pkg::INV_DIVGO:   state_next = awns_pkg::INV_DIVWAIT;
      awns_pkg::INV_DIVWAIT: begin
        if (div_rsp.done) begin
          state_next = (k == 3'd5) ? awns_pkg::INV_IDLE : awns_pkg::INV_DIVGO;
        end
      end
      default:               state_next = awns_pkg::INV_IDLE;
    endcase
    // any coefficient write starts the derivation over
    if (coef_wr) begin
      state_next = awns_pkg::INV_MUL;
    end
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= awns_pkg::Q_ONE;
      coef[1] <= '0;
      coef[2] <= '0;
      coef[3] <= '0;
      coef[4] <= awns_pkg::Q_ONE;
      coef[5] <= '0;
    end else if (coef_wr) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // Inverse and singular flag; reset gives the identity directly
  always_ff @(posedge clk) begin
    if (rst) begin
      inv.m[0]     <= awns_pkg::Q_ONE;
      inv.m[1]     <= '0;
      inv.m[2]     <= '0;
      inv.m[3]     <= '0;
      inv.m[4]     <= awns_pkg::Q_ONE;
      inv.m[5]     <= '0;
      inv.singular <= 1'b0;
      k            <= '0;
    end else if (coef_wr) begin
      k <= '0;
    end else begin
      case (state)
        awns_pkg::INV_MUL: begin
          prod[k] <= mul;
          k       <= (k == 3'd5) ? 3'd0 : k + 3'd1;
        end
        awns_pkg::INV_SUB: begin
          det   <= prod[0] - prod[1];
          num_x <= prod[2] - prod[3];
          num_y <= prod[4] - prod[5];
        end
        awns_pkg::INV_CHK: begin
          inv.singular <= (det == '0);
          k            <= '0;
        end
        awns_pkg::INV_DIVWAIT: begin
          if (div_rsp.done) begin
            inv.m[k] <= div_rsp.quot;
            k        <= k + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/affine_warp_nearest_sampler.sv
// Top level of the affine warp nearest-neighbour sampler.
//
// Input channel (in_valid/in_ready/in_data): a load transfer writes pixel_in
// into the frame store at (col,row), or is dropped when out of range; it
// gives no result. A query transfer maps the output pixel centre through the
// inverse matrix and returns one result on the output channel
// (out_valid/out_ready/out_data); no new item is taken until the query has
// left its last stage, as the four multipliers, the 64-bit sums, the bound
// check and the registered frame store read run one after another.
// A write to any coefficient restarts the inverse derivation: six products,
// then six 128-step divisions for a non-zero determinant, with in_ready low.
// Reset loads the identity inverse at once; the frame store holds nothing
// valid until loaded. The output register lets loads and a new query be
// taken while a result waits; a finished query waits in its last stage
// until the output register is free.
`default_nettype none
module affine_warp_nearest_sampler #(
  parameter int SRC_WIDTH  = awns_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = awns_pkg::SRC_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [awns_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [awns_pkg::COEF_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire awns_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output awns_pkg::out_item_t              out_data
);

  localparam int DEPTH  = SRC_WIDTH * SRC_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] W_A = ADDR_W'(SRC_WIDTH);

  awns_pkg::qry_state_t state, state_next;
  awns_pkg::inv_t       inv;
  logic                 inv_busy;

  logic [awns_pkg::PIXEL_W-1:0] fill_level;
  logic [awns_pkg::COORD_W-1:0] q_col;
  logic [awns_pkg::COORD_W-1:0] q_row;
  logic [60:0]                  px0, px1, py0, py1;
  logic [63:0]                  sum_x, sum_y;
  logic                         hit;

  logic                          in_xfer;
  logic                          load_ok;
  logic [ADDR_W-1:0]             waddr;
  logic [27:0]                   cx, cy;
  logic signed [60:0]            mx0, mx1, my0, my1;
  logic [63:0]                   tx, ty;
  logic                          in_src_direct;
  logic                          in_src_mapped;
  logic [awns_pkg::COORD_W-1:0]  sx, sy;
  logic                          rd_hit;
  logic [ADDR_W-1:0]             raddr;
  logic [awns_pkg::PIXEL_W-1:0]  rdata;
  logic                          out_free;

  assign in_ready = (state == awns_pkg::Q_IDLE) && !inv_busy;
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Fill level register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
    end else if (cfg_wr_en && (cfg_index == awns_pkg::REG_FILL_LEVEL)) begin
      fill_level <= cfg_data[awns_pkg::PIXEL_W-1:0];
    end
  end

  awns_inverse u_inv (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .inv       (inv),
    .busy      (inv_busy)
  );

  // Load path
  assign load_ok = in_xfer && (in_data.func == awns_pkg::FUNC_LOAD) &&
                   ({1'b0, in_data.col} < 13'(SRC_WIDTH)) &&
                   ({1'b0, in_data.row} < 13'(SRC_HEIGHT));
  assign waddr = ADDR_W'(in_data.row) * W_A + ADDR_W'(in_data.col);

  // Pixel centre in Q12.16 and the four products
  assign cx  = {q_col, 1'b1, 15'd0};
  assign cy  = {q_row, 1'b1, 15'd0};
  assign mx0 = 61'($signed(inv.m[0])) * 61'($signed({1'b0, cx}));
  assign mx1 = 61'($signed(inv.m[1])) * 61'($signed({1'b0, cy}));
  assign my0 = 61'($signed(inv.m[3])) * 61'($signed({1'b0, cx}));
  assign my1 = 61'($signed(inv.m[4])) * 61'($signed({1'b0, cy}));

  // Translation terms in Q32.32
  assign tx = {{16{inv.m[2][31]}}, inv.m[2], 16'd0};
  assign ty = {{16{inv.m[5][31]}}, inv.m[5], 16'd0};

  // Bound checks
  assign in_src_direct = ({1'b0, q_col} < 13'(SRC_WIDTH)) &&
                         ({1'b0, q_row} < 13'(SRC_HEIGHT));
  assign in_src_mapped = !sum_x[63] && !sum_y[63] &&
                         (sum_x[63:32] < 32'(SRC_WIDTH)) &&
                         (sum_y[63:32] < 32'(SRC_HEIGHT));
  assign sx     = inv.singular ? q_col : sum_x[32 +: awns_pkg::COORD_W];
  assign sy     = inv.singular ? q_row : sum_y[32 +: awns_pkg::COORD_W];
  assign rd_hit = inv.singular ? in_src_direct : in_src_mapped;
  assign raddr  = ADDR_W'(sy) * W_A + ADDR_W'(sx);

  awns_frame_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (waddr),
    .wdata (in_data.pixel_in),
    .re    ((state == awns_pkg::Q_CHK) && rd_hit),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= awns_pkg::Q_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      awns_pkg::Q_IDLE: begin
        if (in_xfer && (in_data.func == awns_pkg::FUNC_QUERY)) begin
          state_next = awns_pkg::Q_MUL;
        end
      end
      awns_pkg::Q_MUL: state_next = awns_pkg::Q_SUM;
      awns_pkg::Q_SUM: state_next = awns_pkg::Q_CHK;
      awns_pkg::Q_CHK: state_next = awns_pkg::Q_RD;
      awns_pkg::Q_RD:  if (out_free) state_next = awns_pkg::Q_IDLE;
      default:         state_next = awns_pkg::Q_IDLE;
    endcase
  end

  // Query datapath
  always_ff @(posedge clk) begin
    case (state)
      awns_pkg::Q_IDLE: begin
        q_col <= in_data.col;
        q_row <= in_data.row;
      end
      awns_pkg::Q_MUL: begin
        px0 <= mx0;
        px1 <= mx1;
        py0 <= my0;
        py1 <= my1;
      end
      awns_pkg::Q_SUM: begin
        sum_x <= {{3{px0[60]}}, px0} + {{3{px1[60]}}, px1} + tx;
        sum_y <= {{3{py0[60]}}, py0} + {{3{py1[60]}}, py1} + ty;
      end
      awns_pkg::Q_CHK: hit <= rd_hit;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == awns_pkg::Q_RD) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == awns_pkg::Q_RD) && out_free) begin
      out_data.pixel_out  <= hit ? rdata : fill_level;
      out_data.inside_res <= hit;
    end
  end

  // Checks
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.func == awns_pkg::FUNC_QUERY)
    |=> state == awns_pkg::Q_MUL)
    else $error("query transfer did not start the sequencer");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == awns_pkg::Q_RD))
    else $error("result appeared without a finished query");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    (state == awns_pkg::Q_RD) && out_free |=> out_valid && (state == awns_pkg::Q_IDLE))
    else $error("finished query not moved to the output register");

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking bench for the affine warp sampler: loads and queries scored against a Q16.16 model.
module tb;

  localparam int SRC_W        = awns_pkg::SRC_WIDTH_DEF;
  localparam int SRC_H        = awns_pkg::SRC_HEIGHT_DEF;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;
  localparam longint PIXEL_CENTRE = 32768;

  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [awns_pkg::IDX_W-1:0]  cfg_index = awns_pkg::REG_COEF_A;
  logic [awns_pkg::COEF_W-1:0] cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  awns_pkg::in_item_t          in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  awns_pkg::out_item_t         out_data;

  // Warp model state: forward coefficients, derived inverse, frame store copy
  longint                       warp_coef [6];
  longint                       warp_inv [6];
  logic                         warp_singular;
  logic [awns_pkg::PIXEL_W-1:0] fill_pred;
  logic [awns_pkg::PIXEL_W-1:0] frame_copy [SRC_W*SRC_H];
  bit                           loaded_map [SRC_W*SRC_H];

  awns_pkg::in_item_t  pending_items [$];
  awns_pkg::out_item_t expected_pixels [$];
  int                  mismatch_count = 0;
  int                  send_idle_pct  = 10;
  int                  recv_idle_pct  = 45;
  int                  quiet_cycles   = 0;

  affine_warp_nearest_sampler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(num * 2^sh / den), ties away from zero, saturated to signed 32 bit
  function automatic longint rounded_ratio(input longint num, input int sh, input longint den);
    logic [63:0]  num_mag, den_mag;
    logic [127:0] n, d, q, r, lim;
    logic         neg;
    neg     = (num < 0) != (den < 0);
    num_mag = (num < 0) ? -num : num;
    den_mag = (den < 0) ? -den : den;
    n = {64'd0, num_mag} << sh;
    d = {64'd0, den_mag};
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Inverse of the forward matrix; determinant exact in Q32.32
  function automatic void invert_warp();
    longint det;
    det = warp_coef[0] * warp_coef[4] - warp_coef[1] * warp_coef[3];
    warp_singular = (det == 0);
    if (warp_singular) begin
      foreach (warp_inv[k]) warp_inv[k] = 0;
    end else begin
      warp_inv[0] = rounded_ratio(warp_coef[4], 32, det);
      warp_inv[1] = rounded_ratio(-warp_coef[1], 32, det);
      warp_inv[2] = rounded_ratio(warp_coef[1] * warp_coef[5] - warp_coef[2] * warp_coef[4],
                                  16, det);
      warp_inv[3] = rounded_ratio(-warp_coef[3], 32, det);
      warp_inv[4] = rounded_ratio(warp_coef[0], 32, det);
      warp_inv[5] = rounded_ratio(warp_coef[2] * warp_coef[3] - warp_coef[0] * warp_coef[5],
                                  16, det);
    end
  endfunction

  // Frame store index that an output pixel samples; hit_src flags a hit
  function automatic int src_index(input logic [awns_pkg::COORD_W-1:0] col,
                                   input logic [awns_pkg::COORD_W-1:0] row,
                                   output logic hit_src);
    longint cx, cy, x, y;
    if (warp_singular) begin
      hit_src = (col < SRC_W) && (row < SRC_H);
      return hit_src ? int'(row) * SRC_W + int'(col) : 0;
    end
    cx = longint'(col) * longint'(awns_pkg::Q_ONE) + PIXEL_CENTRE;
    cy = longint'(row) * longint'(awns_pkg::Q_ONE) + PIXEL_CENTRE;
    x  = warp_inv[0] * cx + warp_inv[1] * cy + warp_inv[2] * longint'(awns_pkg::Q_ONE);
    y  = warp_inv[3] * cx + warp_inv[4] * cy + warp_inv[5] * longint'(awns_pkg::Q_ONE);
    hit_src = x >= 0 && y >= 0 && x < (longint'(SRC_W) <<< 32) && y < (longint'(SRC_H) <<< 32);
    return hit_src ? int'(y >>> 32) * SRC_W + int'(x >>> 32) : 0;
  endfunction

  // Expected behaviour of one accepted transfer
  function automatic void apply_transfer(input awns_pkg::in_item_t item);
    awns_pkg::out_item_t res;
    logic                hit_src;
    int                  idx;
    if (item.func == awns_pkg::FUNC_LOAD) begin
      if (item.col < SRC_W && item.row < SRC_H)
        frame_copy[int'(item.row) * SRC_W + int'(item.col)] = item.pixel_in;
    end else begin
      idx = src_index(item.col, item.row, hit_src);
      res.inside_res = hit_src;
      res.pixel_out  = hit_src ? frame_copy[idx] : fill_pred;
      expected_pixels.push_back(res);
    end
  endfunction

  function automatic void add_load(input logic [awns_pkg::COORD_W-1:0] col,
                                   input logic [awns_pkg::COORD_W-1:0] row,
                                   input logic [awns_pkg::PIXEL_W-1:0] pix);
    awns_pkg::in_item_t item;
    item.func     = awns_pkg::FUNC_LOAD;
    item.col      = col;
    item.row      = row;
    item.pixel_in = pix;
    pending_items.push_back(item);
    if (col < SRC_W && row < SRC_H) loaded_map[int'(row) * SRC_W + int'(col)] = 1'b1;
  endfunction

  // Query, preceded by a load of its source pixel if that was never written
  function automatic void add_query(input logic [awns_pkg::COORD_W-1:0] col,
                                    input logic [awns_pkg::COORD_W-1:0] row,
                                    input logic [awns_pkg::PIXEL_W-1:0] pix);
    awns_pkg::in_item_t item;
    logic               hit_src;
    int                 idx;
    idx = src_index(col, row, hit_src);
    if (hit_src && !loaded_map[idx])
      add_load(awns_pkg::COORD_W'(idx % SRC_W), awns_pkg::COORD_W'(idx / SRC_W),
               awns_pkg::PIXEL_W'($urandom));
    item.func     = awns_pkg::FUNC_QUERY;
    item.col      = col;
    item.row      = row;
    item.pixel_in = pix;
    pending_items.push_back(item);
  endfunction

  function automatic void add_random_item();
    logic [awns_pkg::COORD_W-1:0] col, row;
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 9) == 0) begin
        col = awns_pkg::COORD_W'($urandom);
        row = awns_pkg::COORD_W'($urandom);
      end else begin
        col = awns_pkg::COORD_W'($urandom_range(0, SRC_W - 1));
        row = awns_pkg::COORD_W'($urandom_range(0, SRC_H - 1));
      end
      add_load(col, row, awns_pkg::PIXEL_W'($urandom));
    end else begin
      if ($urandom_range(0, 99) < 15) begin
        col = awns_pkg::COORD_W'($urandom);
        row = awns_pkg::COORD_W'($urandom);
      end else begin
        col = awns_pkg::COORD_W'($urandom_range(0, SRC_W + 43));
        row = awns_pkg::COORD_W'($urandom_range(0, SRC_H + 43));
      end
      add_query(col, row, awns_pkg::PIXEL_W'($urandom));
    end
  endfunction

  function automatic logic [awns_pkg::COEF_W-1:0] signed_pick(input int unsigned lo,
                                                              input int unsigned hi);
    logic [awns_pkg::COEF_W-1:0] mag;
    mag = awns_pkg::COEF_W'($urandom_range(lo, hi));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic write_register(input logic [awns_pkg::IDX_W-1:0] idx,
                                input logic [awns_pkg::COEF_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == awns_pkg::REG_FILL_LEVEL) begin
      fill_pred = value[awns_pkg::PIXEL_W-1:0];
    end else begin
      warp_coef[idx] = longint'($signed(value));
      invert_warp();
    end
  endtask

  task automatic set_warp(input logic [awns_pkg::COEF_W-1:0] a,
                          input logic [awns_pkg::COEF_W-1:0] b,
                          input logic [awns_pkg::COEF_W-1:0] c,
                          input logic [awns_pkg::COEF_W-1:0] d,
                          input logic [awns_pkg::COEF_W-1:0] e,
                          input logic [awns_pkg::COEF_W-1:0] f,
                          input logic [awns_pkg::PIXEL_W-1:0] fill);
    write_register(awns_pkg::REG_COEF_A, a);
    write_register(awns_pkg::REG_COEF_B, b);
    write_register(awns_pkg::REG_COEF_C, c);
    write_register(awns_pkg::REG_COEF_D, d);
    write_register(awns_pkg::REG_COEF_E, e);
    write_register(awns_pkg::REG_COEF_F, f);
    write_register(awns_pkg::REG_FILL_LEVEL,
                   {{(awns_pkg::COEF_W-awns_pkg::PIXEL_W){1'b0}}, fill});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sampled at the falling edge so the handshake state has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [awns_pkg::COEF_W-1:0] a,
                           input logic [awns_pkg::COEF_W-1:0] b,
                           input logic [awns_pkg::COEF_W-1:0] c,
                           input logic [awns_pkg::COEF_W-1:0] d,
                           input logic [awns_pkg::COEF_W-1:0] e,
                           input logic [awns_pkg::COEF_W-1:0] f,
                           input logic [awns_pkg::PIXEL_W-1:0] fill, input int n);
    wait_idle();
    set_warp(a, b, c, d, e, f, fill);
    repeat (n) add_random_item();
  endtask

  // Mild scales, shears and shifts, so most queries land in the source
  task automatic random_phase(input int n);
    run_phase(signed_pick(16384, 262144), signed_pick(0, 32768), signed_pick(0, 64 << 16),
              signed_pick(0, 32768), signed_pick(16384, 262144), signed_pick(0, 64 << 16),
              awns_pkg::PIXEL_W'($urandom), n);
  endtask

  // Input driver: payload held until the transfer completes
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: score results, then predict from accepted inputs
  always @(posedge clk) begin : watch_channels
    awns_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("tb: unexpected result pixel_out %h inside_res %b",
                     out_data.pixel_out, out_data.inside_res);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_out !== want.pixel_out || out_data.inside_res !== want.inside_res)
          begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("tb: mismatch pixel_out exp %h got %h, inside_res exp %b got %b",
                       want.pixel_out, out_data.pixel_out, want.inside_res, out_data.inside_res);
          end
        end
      end
      if (in_valid && in_ready) apply_transfer(in_data);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    warp_coef = '{65536, 0, 0, 0, 65536, 0};
    fill_pred = '0;
    invert_warp();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Identity after reset: corners, value extremes, ignored loads, outside points
    add_load(12'd0, 12'd0, 16'hFFFF);
    add_load(12'd255, 12'd255, 16'h0000);
    add_load(12'd255, 12'd0, 16'hAAAA);
    add_load(12'd0, 12'd255, 16'h5555);
    add_load(12'd256, 12'd0, 16'h1111);
    add_load(12'd0, 12'd4095, 16'h2222);
    add_load(12'd4095, 12'd4095, 16'hFFFF);
    add_query(12'd0, 12'd0, 16'hFFFF);
    add_query(12'd255, 12'd255, 16'h0000);
    add_query(12'd255, 12'd0, 16'h0000);
    add_query(12'd0, 12'd255, 16'h0000);
    add_query(12'd256, 12'd0, 16'h0000);
    add_query(12'd0, 12'd4095, 16'h0000);
    add_query(12'd4095, 12'd4095, 16'hFFFF);

    // Singular matrix: pass-through sampling, full fill level
    wait_idle();
    set_warp(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF);
    add_query(12'd0, 12'd0, 16'h0000);
    add_query(12'd255, 12'd255, 16'h0000);
    add_query(12'd4095, 12'd0, 16'h0000);
    add_query(12'd12, 12'd300, 16'h0000);
    add_load(12'd10, 12'd10, 16'h0F0F);
    add_query(12'd10, 12'd10, 16'h0000);

    // Sender idles lightly, receiver heavily
    run_phase(32'h0002_0000, 32'h0, 32'hFFF6_0000, 32'h0, 32'h0002_0000, 32'hFFF6_0000,
              awns_pkg::PIXEL_W'($urandom), 80);                  // x2 zoom, shifted
    run_phase(32'hFFFF_0000, 32'h0, 32'h0100_0000, 32'h0, 32'h0001_0000, 32'h0,
              16'h1234, 80);                                      // mirror in x
    random_phase(80);

    // Roles swapped
    send_idle_pct = 45;
    recv_idle_pct = 10;
    run_phase(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000,
              16'hFFFF, 45);                                      // coefficient extremes
    run_phase(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0,
              16'h8001, 30);                                      // shear extremes, swap axes
    run_phase(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
              16'h7FFE, 30);                                      // inverse saturates
    run_phase(32'h0001_0000, 32'h0001_0000, signed_pick(0, 64 << 16),
              32'h0001_0000, 32'h0001_0000, signed_pick(0, 64 << 16),
              awns_pkg::PIXEL_W'($urandom), 80);                  // singular, non-zero
    random_phase(80);
    random_phase(80);

    // No idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(80);
    random_phase(80);
    random_phase(80);
    random_phase(80);
    run_phase(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 16'h0000, 80);

    wait_idle();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: affine_warp_nearest_sampler.f
rtl/awns_pkg.sv
rtl/awns_frame_ram.sv
rtl/awns_divider.sv
rtl/awns_inverse.sv
rtl/affine_warp_nearest_sampler.sv
sim/tb.sv
